[src/jamp_pkg.sv]
// jamp_pkg: shared widths, reset values, job record and the cordic angle table
// for the joystick angle-mode processor; used by every module of the block.
`default_nettype none
package jamp_pkg;

  localparam int AVG_DEPTH_DEF = 15;
  localparam int SAMPLE_W      = 12;
  localparam int THRESH_W      = 13;
  localparam int MAP_W         = 13;          // signed deviation / offset
  localparam int SQ_W          = 2 * MAP_W;   // squares of offsets and thresholds
  localparam int DIST_W        = SQ_W + 1;
  localparam int ANGLE_W       = 9;
  localparam int QUEUE_DEPTH   = 2;

  localparam logic [SAMPLE_W-1:0] CENTER_RST = 12'd2048;
  localparam logic [THRESH_W-1:0] WAKE_RST   = 13'd500;
  localparam logic [THRESH_W-1:0] DEAD_RST   = 13'd150;

  // register indexes on the configuration port
  localparam logic [1:0] REG_CENTER_X = 2'd0;
  localparam logic [1:0] REG_CENTER_Y = 2'd1;
  localparam logic [1:0] REG_WAKE     = 2'd2;
  localparam logic [1:0] REG_DEAD     = 2'd3;

  // result kinds
  localparam logic KIND_NOTICE = 1'b0;
  localparam logic KIND_ANGLE  = 1'b1;

  localparam int CORDIC_STEPS = 20;
  localparam int STEP_W       = 5;
  localparam int CW           = 32;           // cordic x/y in Q16
  localparam int ZW           = 26;           // angle accumulator, Q16 degrees
  localparam int FRAC         = 16;

  typedef struct packed {
    logic                    notice;
    logic                    angle;
    logic signed [MAP_W-1:0] mx;
    logic signed [MAP_W-1:0] my;
  } job_t;

  function automatic logic signed [ZW-1:0] atan_q16(input logic [STEP_W-1:0] i);
    logic signed [ZW-1:0] v;
    case (i)
      5'd0:  v = 26'sd2949120;
      5'd1:  v = 26'sd1740967;
      5'd2:  v = 26'sd919879;
      5'd3:  v = 26'sd466945;
      5'd4:  v = 26'sd234379;
      5'd5:  v = 26'sd117304;
      5'd6:  v = 26'sd58666;
      5'd7:  v = 26'sd29335;
      5'd8:  v = 26'sd14668;
      5'd9:  v = 26'sd7334;
      5'd10: v = 26'sd3667;
      5'd11: v = 26'sd1833;
      5'd12: v = 26'sd917;
      5'd13: v = 26'sd458;
      5'd14: v = 26'sd229;
      5'd15: v = 26'sd115;
      5'd16: v = 26'sd57;
      5'd17: v = 26'sd29;
      5'd18: v = 26'sd14;
      5'd19: v = 26'sd7;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

[src/jamp_front.sv]
// jamp_front: accepts samples, keeps the moving averages, forms offsets and
// squared distance, runs the mode flag and pushes jobs. Depends on jamp_pkg.
`default_nettype none
module jamp_front #(
  parameter int AVG_DEPTH = jamp_pkg::AVG_DEPTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              push,
  output logic                                   full,
  input  wire logic [jamp_pkg::SAMPLE_W-1:0]     in_sample_x,
  input  wire logic [jamp_pkg::SAMPLE_W-1:0]     in_sample_y,
  input  wire logic                              in_button_pressed,
  input  wire logic [jamp_pkg::SAMPLE_W-1:0]     center_x,
  input  wire logic [jamp_pkg::SAMPLE_W-1:0]     center_y,
  input  wire logic [jamp_pkg::THRESH_W-1:0]     wake_threshold,
  input  wire logic [jamp_pkg::THRESH_W-1:0]     dead_zone,
  input  wire logic                              q_full,
  output logic                                   job_push,
  output jamp_pkg::job_t                         job
);
  import jamp_pkg::*;

  localparam int L      = $clog2(AVG_DEPTH);
  localparam int SLOT_W = (L > 0) ? L : 1;
  localparam int SUM_W  = MAP_W + L;
  localparam int K      = SUM_W + L;
  localparam int PROD_W = 2 * SUM_W + 1;
  localparam longint RECIP_L = ((64'd1 << K) + AVG_DEPTH - 1) / AVG_DEPTH;
  localparam logic [SUM_W:0] RECIP = RECIP_L[SUM_W:0];
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(AVG_DEPTH - 1);
  localparam logic [SUM_W-1:0] DM1 = SUM_W'(AVG_DEPTH - 1);

  typedef enum logic [2:0] {F_IDLE, F_SUM, F_DIV, F_SQ, F_DEC} fstate_t;

  fstate_t                  state_r;
  logic signed [MAP_W-1:0]  dx_r, dy_r;
  logic                     press_r;
  logic signed [MAP_W-1:0]  hist_x_r [AVG_DEPTH];
  logic signed [MAP_W-1:0]  hist_y_r [AVG_DEPTH];
  logic signed [SUM_W-1:0]  sum_x_r, sum_y_r;
  logic [SLOT_W-1:0]        slot_r;
  logic [PROD_W-1:0]        prod_x_r, prod_y_r;
  logic                     neg_x_r, neg_y_r;
  logic signed [MAP_W-1:0]  mx_r, my_r;
  logic [SQ_W-1:0]          sq_x_r, sq_y_r, sq_w_r, sq_d_r;
  logic                     auto_r;
  logic                     job_push_r;
  job_t                     job_r;

  logic signed [SUM_W-1:0]  sum_x_nxt, sum_y_nxt;
  logic [SUM_W-1:0]         ax, ay;
  logic [MAP_W-1:0]         qx, qy;
  logic signed [MAP_W-1:0]  mx_nxt, my_nxt;
  logic [DIST_W-1:0]        d2;
  logic                     notice, auto_mid, auto_nxt, ang;

  always_comb begin
    sum_x_nxt = sum_x_r - SUM_W'(hist_x_r[slot_r]) + SUM_W'(dx_r);
    sum_y_nxt = sum_y_r - SUM_W'(hist_y_r[slot_r]) + SUM_W'(dy_r);
    // floor division: negative sums are biased so the quotient rounds down
    ax = sum_x_r[SUM_W-1] ? (-sum_x_r) + DM1 : sum_x_r;
    ay = sum_y_r[SUM_W-1] ? (-sum_y_r) + DM1 : sum_y_r;
    qx = MAP_W'(prod_x_r >> K);
    qy = MAP_W'(prod_y_r >> K);
    mx_nxt = neg_x_r ? $signed(qx) : -$signed(qx);
    my_nxt = neg_y_r ? $signed(qy) : -$signed(qy);
    d2 = DIST_W'(sq_x_r) + DIST_W'(sq_y_r);
    notice   = press_r && !auto_r;
    auto_mid = auto_r || notice;
    auto_nxt = auto_mid && !(d2 > DIST_W'(sq_w_r));
    ang      = !auto_nxt && (d2 > DIST_W'(sq_d_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= F_IDLE;
      sum_x_r    <= '0;
      sum_y_r    <= '0;
      slot_r     <= '0;
      auto_r     <= 1'b1;
      job_push_r <= 1'b0;
      for (int i = 0; i < AVG_DEPTH; i++) begin
        hist_x_r[i] <= '0;
        hist_y_r[i] <= '0;
      end
    end else begin
      job_push_r <= (state_r == F_DEC) && !q_full && (notice || ang);
      case (state_r)
        F_IDLE: begin
          if (push) begin
            dx_r    <= $signed({1'b0, in_sample_x}) - $signed({1'b0, center_x});
            dy_r    <= $signed({1'b0, in_sample_y}) - $signed({1'b0, center_y});
            press_r <= in_button_pressed;
            state_r <= F_SUM;
          end
        end
        F_SUM: begin
          sum_x_r <= sum_x_nxt;
          sum_y_r <= sum_y_nxt;
          hist_x_r[slot_r] <= dx_r;
          hist_y_r[slot_r] <= dy_r;
          slot_r  <= (slot_r == LAST_SLOT) ? '0 : slot_r + 1'b1;
          state_r <= F_DIV;
        end
        F_DIV: begin
          prod_x_r <= PROD_W'(ax) * PROD_W'(RECIP);
          prod_y_r <= PROD_W'(ay) * PROD_W'(RECIP);
          neg_x_r  <= sum_x_r[SUM_W-1];
          neg_y_r  <= sum_y_r[SUM_W-1];
          state_r  <= F_SQ;
        end
        F_SQ: begin
          mx_r   <= mx_nxt;
          my_r   <= my_nxt;
          sq_x_r <= SQ_W'(mx_nxt * mx_nxt);
          sq_y_r <= SQ_W'(my_nxt * my_nxt);
          sq_w_r <= SQ_W'(wake_threshold) * SQ_W'(wake_threshold);
          sq_d_r <= SQ_W'(dead_zone) * SQ_W'(dead_zone);
          state_r <= F_DEC;
        end
        F_DEC: begin
          if (!q_full) begin
            auto_r       <= auto_nxt;
            job_r.notice <= notice;
            job_r.angle  <= ang;
            job_r.mx     <= mx_r;
            job_r.my     <= my_r;
            state_r      <= F_IDLE;
          end
        end
        default: state_r <= F_IDLE;
      endcase
    end
  end

  assign full     = (state_r != F_IDLE);
  assign job_push = job_push_r;
  assign job      = job_r;

endmodule
`default_nettype wire

[src/jamp_queue.sv]
// jamp_queue: short job queue between the front and the back parts.
// Depends on jamp_pkg for the job record and depth.
`default_nettype none
module jamp_queue (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      wr,
  input  jamp_pkg::job_t wdata,
  output logic           q_full,
  input  wire logic      rd,
  output logic           q_valid,
  output jamp_pkg::job_t rdata
);
  import jamp_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);

  job_t          mem_r [QUEUE_DEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [PW:0]   cnt_r;
  logic          do_wr, do_rd;

  assign q_full  = (cnt_r == (PW+1)'(QUEUE_DEPTH));
  assign q_valid = (cnt_r != '0);
  assign rdata   = mem_r[rp_r];
  assign do_wr   = wr && !q_full;
  assign do_rd   = rd && q_valid;

  always_ff @(posedge clk) begin
    if (do_wr) mem_r[wp_r] <= wdata;
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_wr) wp_r <= wp_r + 1'b1;
      if (do_rd) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (PW+1)'(do_wr) - (PW+1)'(do_rd);
    end
  end

endmodule
`default_nettype wire

[src/jamp_back.sv]
// jamp_back: takes jobs, emits auto notice and servo angle through a one-word
// output register; non-special angles use an iterative cordic. Uses jamp_pkg.
`default_nettype none
module jamp_back (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         q_valid,
  input  jamp_pkg::job_t                    qdata,
  output logic                              q_rd,
  output logic                              empty,
  input  wire logic                         pop,
  output logic                              out_kind,
  output logic [jamp_pkg::ANGLE_W-1:0]      out_angle,
  output logic                              out_last
);
  import jamp_pkg::*;

  typedef enum logic [2:0] {B_IDLE, B_NOTE, B_SETUP, B_CORD, B_FIN, B_ANG} bstate_t;

  localparam logic signed [ZW-1:0] Z90  = ZW'(90 <<< FRAC);
  localparam logic signed [ZW-1:0] Z180 = ZW'(180 <<< FRAC);
  localparam logic [ANGLE_W-1:0]   A0   = 9'd0;
  localparam logic [ANGLE_W-1:0]   A45  = 9'd45;
  localparam logic [ANGLE_W-1:0]   A90  = 9'd90;
  localparam logic [ANGLE_W-1:0]   A135 = 9'd135;
  localparam logic [ANGLE_W-1:0]   A180 = 9'd180;
  localparam logic [ANGLE_W-1:0]   A270 = 9'd270;
  localparam logic [STEP_W-1:0]    LAST_STEP = STEP_W'(CORDIC_STEPS - 1);

  bstate_t                state_r;
  job_t                   job_r;
  logic signed [CW-1:0]   x_r, y_r;
  logic signed [ZW-1:0]   z_r;
  logic [STEP_W-1:0]      i_r;
  logic [ANGLE_W-1:0]     ang_r;
  logic                   ov_r, kind_r, last_r;
  logic [ANGLE_W-1:0]     oang_r;
  logic                   slot_free;
  logic                   load_out;

  logic signed [CW-1:0]   xs, ys, mxq, myq;
  logic signed [ZW-1:0]   zc;
  logic [ANGLE_W-1:0]     deg;
  logic                   special;
  logic [ANGLE_W-1:0]     sp_ang;

  assign slot_free = !ov_r || pop;
  assign load_out  = slot_free &&
                     (((state_r == B_NOTE) && job_r.notice) || (state_r == B_ANG));

  always_comb begin
    xs  = x_r >>> i_r;
    ys  = y_r >>> i_r;
    mxq = CW'(job_r.mx) <<< FRAC;
    myq = CW'(job_r.my) <<< FRAC;
    if (z_r < 0)          zc = '0;
    else if (z_r >= Z180) zc = Z180 - 1'b1;
    else                  zc = z_r;
    deg = ANGLE_W'(zc >>> FRAC);
    special = 1'b1;
    sp_ang  = A0;
    if (job_r.my < 0) begin
      if (job_r.mx > 0)      sp_ang = A180;
      else if (job_r.mx < 0) sp_ang = A0;
      else                   sp_ang = A270;
    end else if (job_r.my == 0) begin
      sp_ang = (job_r.mx > 0) ? A180 : A0;
    end else if (job_r.mx == 0) begin
      sp_ang = A90;
    end else if (job_r.mx == job_r.my) begin
      sp_ang = A135;
    end else if (job_r.mx == -job_r.my) begin
      sp_ang = A45;
    end else begin
      special = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      ov_r    <= 1'b0;
    end else begin
      ov_r <= load_out || (ov_r && !pop);
      case (state_r)
        B_IDLE: begin
          if (q_valid) begin
            job_r   <= qdata;
            state_r <= B_NOTE;
          end
        end
        B_NOTE: begin
          if (!job_r.notice) begin
            state_r <= B_SETUP;
          end else if (slot_free) begin
            kind_r  <= KIND_NOTICE;
            oang_r  <= A0;
            last_r  <= !job_r.angle;
            state_r <= B_SETUP;
          end
        end
        B_SETUP: begin
          if (!job_r.angle) begin
            state_r <= B_IDLE;
          end else if (special) begin
            ang_r   <= sp_ang;
            state_r <= B_ANG;
          end else begin
            // rotate into the right half plane first for negative x
            if (job_r.mx >= 0) begin
              x_r <= mxq;
              y_r <= myq;
              z_r <= '0;
            end else begin
              x_r <= myq;
              y_r <= -mxq;
              z_r <= Z90;
            end
            i_r     <= '0;
            state_r <= B_CORD;
          end
        end
        B_CORD: begin
          if (y_r > 0) begin
            x_r <= x_r + ys;
            y_r <= y_r - xs;
            z_r <= z_r + atan_q16(i_r);
          end else if (y_r < 0) begin
            x_r <= x_r - ys;
            y_r <= y_r + xs;
            z_r <= z_r - atan_q16(i_r);
          end
          i_r <= i_r + 1'b1;
          if (i_r == LAST_STEP) state_r <= B_FIN;
        end
        B_FIN: begin
          ang_r   <= A180 - deg;
          state_r <= B_ANG;
        end
        B_ANG: begin
          if (slot_free) begin
            kind_r  <= KIND_ANGLE;
            oang_r  <= ang_r;
            last_r  <= 1'b1;
            state_r <= B_IDLE;
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

  assign q_rd      = (state_r == B_IDLE) && q_valid;
  assign empty     = !ov_r;
  assign out_kind  = kind_r;
  assign out_angle = oang_r;
  assign out_last  = last_r;

endmodule
`default_nettype wire

[src/joystick_angle_mode_processor_core.sv]
// Top level of the joystick angle-mode processor: configuration registers,
// front, job queue and back. Depends on jamp_pkg and the jamp_* modules.
//
// An accepted word is taken by the front part through capture, running-sum
// update, reciprocal multiply, squaring and mode decision; full stays high
// until then, and the mode decision waits while the two-entry job queue is
// full. The back part computes an angle that needs the cordic with one
// micro-rotation per cycle over 20 steps; notices and the directions that are
// resolved without it skip the cordic. Results wait in a one-word output
// register until popped. The averaging history is cleared at reset.
`default_nettype none
module joystick_angle_mode_processor_core #(
  parameter int AVG_DEPTH = jamp_pkg::AVG_DEPTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           push,
  output logic                                full,
  input  wire logic [jamp_pkg::SAMPLE_W-1:0]  in_sample_x,
  input  wire logic [jamp_pkg::SAMPLE_W-1:0]  in_sample_y,
  input  wire logic                           in_button_pressed,
  output logic                                empty,
  input  wire logic                           pop,
  output logic                                out_kind,
  output logic [jamp_pkg::ANGLE_W-1:0]        out_angle,
  output logic                                out_last,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [3:0]                     paddr,
  input  wire logic [31:0]                    pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);
  import jamp_pkg::*;

  logic [SAMPLE_W-1:0] center_x_r, center_y_r;
  logic [THRESH_W-1:0] wake_r, dead_r;
  logic                cfg_we;
  logic                q_full, q_valid, q_rd, job_push;
  job_t                job_w, job_q;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r <= CENTER_RST;
      center_y_r <= CENTER_RST;
      wake_r     <= WAKE_RST;
      dead_r     <= DEAD_RST;
    end else if (cfg_we) begin
      case (paddr[3:2])
        REG_CENTER_X: center_x_r <= pwdata[SAMPLE_W-1:0];
        REG_CENTER_Y: center_y_r <= pwdata[SAMPLE_W-1:0];
        REG_WAKE:     wake_r     <= pwdata[THRESH_W-1:0];
        REG_DEAD:     dead_r     <= pwdata[THRESH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_CENTER_X: prdata = 32'(center_x_r);
      REG_CENTER_Y: prdata = 32'(center_y_r);
      REG_WAKE:     prdata = 32'(wake_r);
      REG_DEAD:     prdata = 32'(dead_r);
      default:      prdata = '0;
    endcase
  end

  jamp_front #(.AVG_DEPTH(AVG_DEPTH)) u_front (
    .clk, .rst_n, .push, .full,
    .in_sample_x, .in_sample_y, .in_button_pressed,
    .center_x(center_x_r), .center_y(center_y_r),
    .wake_threshold(wake_r), .dead_zone(dead_r),
    .q_full, .job_push, .job(job_w)
  );

  jamp_queue u_queue (
    .clk, .rst_n, .wr(job_push), .wdata(job_w), .q_full,
    .rd(q_rd), .q_valid, .rdata(job_q)
  );

  jamp_back u_back (
    .clk, .rst_n, .q_valid, .qdata(job_q), .q_rd,
    .empty, .pop, .out_kind, .out_angle, .out_last
  );

endmodule
`default_nettype wire

[src/jamp_checker.sv]
// jamp_checker: port-level checks on the result channel of the processor,
// bound to joystick_angle_mode_processor_core. Uses jamp_pkg result kinds.
`default_nettype none
module jamp_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       empty,
  input wire logic       pop,
  input wire logic       out_kind,
  input wire logic [8:0] out_angle,
  input wire logic       out_last
);
  import jamp_pkg::*;

  a_empty_after_reset: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result queue not empty after reset");

  a_notice_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_kind == KIND_NOTICE) |-> out_angle == '0)
    else $error("notice word with nonzero angle");

  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_kind == KIND_ANGLE) |-> (out_angle <= 9'd180 || out_angle == 9'd270))
    else $error("angle out of range");

  a_angle_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_kind == KIND_ANGLE) |-> out_last)
    else $error("angle word not marked last");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_angle) && $stable(out_kind)))
    else $error("waiting word changed");

endmodule

bind joystick_angle_mode_processor_core jamp_checker u_jamp_checker (
  .clk, .rst_n, .empty, .pop, .out_kind, .out_angle, .out_last
);
`default_nettype wire

[test/tb_top.sv]
// tb_top: self-checking testbench for joystick_angle_mode_processor_core; a queue-fed
// driver, a result monitor and an in-bench model of averaging, mode and angle logic.
// Depends on jamp_pkg and the core RTL only.
`default_nettype none
module tb_top;
  import jamp_pkg::*;

  localparam int DEPTH    = 15;
  localparam int DRAIN    = 80;
  localparam int WD_LIMIT = 20000;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sx;
    logic [SAMPLE_W-1:0] sy;
    logic                btn;
  } stick_word_t;

  typedef struct packed {
    logic               kind;
    logic [ANGLE_W-1:0] angle;
    logic               last;
  } servo_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic push = 1'b0;
  logic full;
  logic [SAMPLE_W-1:0] in_sample_x = '0;
  logic [SAMPLE_W-1:0] in_sample_y = '0;
  logic in_button_pressed = 1'b0;
  logic empty;
  logic pop = 1'b0;
  logic out_kind;
  logic [ANGLE_W-1:0] out_angle;
  logic out_last;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  joystick_angle_mode_processor_core i_dut (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full),
    .in_sample_x(in_sample_x), .in_sample_y(in_sample_y),
    .in_button_pressed(in_button_pressed),
    .empty(empty), .pop(pop), .out_kind(out_kind), .out_angle(out_angle),
    .out_last(out_last), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // stimulus and expectations
  stick_word_t   pending_words[$];
  servo_result_t expected_results[$];
  int src_idle = 0;
  int snk_idle = 0;
  bit running = 0;
  bit word_taken = 0;
  int errors = 0;
  int words_sent = 0;
  int results_seen = 0;
  int angles_seen = 0;
  int notices_seen = 0;
  int quiet_cycles = 0;

  // model state
  int   x_hist[DEPTH];
  int   y_hist[DEPTH];
  int   x_acc, y_acc, hist_slot;
  bit   in_auto;
  logic [SAMPLE_W-1:0] cfg_cx, cfg_cy;
  logic [THRESH_W-1:0] cfg_wake, cfg_dead;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int floor_div_depth(input int s);
    if (s >= 0) return s / DEPTH;
    return -((-s + DEPTH - 1) / DEPTH);
  endfunction

  function automatic int cordic_degrees(input int mx, input int my);
    longint x, y, z, nx;
    longint tbl[CORDIC_STEPS];
    tbl = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
            14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7};
    if (mx >= 0) begin
      x = longint'(mx) * 65536;
      y = longint'(my) * 65536;
      z = 0;
    end else begin
      x = longint'(my) * 65536;
      y = -longint'(mx) * 65536;
      z = 90 * 65536;
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      if (y > 0) begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        x  = nx;
        z += tbl[i];
      end else if (y < 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        x  = nx;
        z -= tbl[i];
      end
    end
    if (z < 0) z = 0;
    if (z >= 180 * 65536) z = 180 * 65536 - 1;
    return int'(z / 65536);
  endfunction

  function automatic int servo_degrees(input int mx, input int my);
    if (my < 0) begin
      if (mx > 0) return 180;
      if (mx < 0) return 0;
      return 270;  // straight down keeps the odd value
    end
    if (my == 0) return (mx > 0) ? 180 : 0;
    if (mx == 0) return 90;
    if (mx == my) return 135;
    if (mx == -my) return 45;
    return 180 - cordic_degrees(mx, my);
  endfunction

  task automatic predict_stick(input stick_word_t w);
    int dx, dy, mx, my, n;
    longint d2, t;
    servo_result_t r[2];
    dx = int'(w.sx) - int'(cfg_cx);
    dy = int'(w.sy) - int'(cfg_cy);
    n = 0;
    x_acc = x_acc - x_hist[hist_slot] + dx;
    y_acc = y_acc - y_hist[hist_slot] + dy;
    x_hist[hist_slot] = dx;
    y_hist[hist_slot] = dy;
    hist_slot = (hist_slot + 1 >= DEPTH) ? 0 : hist_slot + 1;
    mx = -floor_div_depth(x_acc);
    my = -floor_div_depth(y_acc);
    d2 = longint'(mx) * mx + longint'(my) * my;
    if (w.btn && !in_auto) begin
      in_auto = 1;
      r[n] = '{kind: KIND_NOTICE, angle: '0, last: 1'b0};
      n++;
    end
    t = longint'(cfg_wake);
    if (in_auto && d2 > t * t) in_auto = 0;
    t = longint'(cfg_dead);
    if (!in_auto && d2 > t * t) begin
      r[n] = '{kind: KIND_ANGLE, angle: ANGLE_W'(servo_degrees(mx, my)), last: 1'b0};
      n++;
    end
    if (n > 0) r[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) expected_results.push_back(r[i]);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_CENTER_X: cfg_cx = val[SAMPLE_W-1:0];
      REG_CENTER_Y: cfg_cy = val[SAMPLE_W-1:0];
      REG_WAKE:     cfg_wake = val[THRESH_W-1:0];
      REG_DEAD:     cfg_dead = val[THRESH_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_centers_thresholds(input int cx, input int cy, input int wk, input int dz);
    write_reg(REG_CENTER_X, cx);
    write_reg(REG_CENTER_Y, cy);
    write_reg(REG_WAKE, wk);
    write_reg(REG_DEAD, dz);
  endtask

  function automatic int clamp_sample(input int v);
    if (v < 0) return 0;
    if (v > 4095) return 4095;
    return v;
  endfunction

  // a held stick position with jitter, or noise now and then
  task automatic add_gestures(input int count);
    int made, hold, tx, ty, d, jit, shape;
    stick_word_t w;
    made = 0;
    while (made < count) begin
      if ($urandom_range(9) == 0) begin
        w = '{sx: SAMPLE_W'($urandom_range(4095)), sy: SAMPLE_W'($urandom_range(4095)),
              btn: 1'($urandom_range(1))};
        pending_words.push_back(w);
        made++;
      end else begin
        shape = $urandom_range(5);
        d = $urandom_range(2100);
        if ($urandom_range(1)) d = -d;
        case (shape)
          0: begin tx = int'(cfg_cx) + d; ty = int'(cfg_cy); end
          1: begin tx = int'(cfg_cx); ty = int'(cfg_cy) + d; end
          2: begin tx = int'(cfg_cx) + d; ty = int'(cfg_cy) + d; end
          3: begin tx = int'(cfg_cx) + d; ty = int'(cfg_cy) - d; end
          default: begin tx = $urandom_range(4095); ty = $urandom_range(4095); end
        endcase
        hold = $urandom_range(30, 4);
        jit = ($urandom_range(2) == 0) ? 0 : $urandom_range(6);
        for (int i = 0; i < hold; i++) begin
          w.sx = SAMPLE_W'(clamp_sample(tx + $urandom_range(2 * jit) - jit));
          w.sy = SAMPLE_W'(clamp_sample(ty + $urandom_range(2 * jit) - jit));
          w.btn = ($urandom_range(19) == 0);
          pending_words.push_back(w);
          made++;
        end
      end
    end
  endtask

  task automatic drain_all;
    while (pending_words.size() != 0 || expected_results.size() != 0) @(posedge clk);
    // a word with no result may still be in the back end
    repeat (DRAIN) @(posedge clk);
  endtask

  // driver
  always @(negedge clk) begin
    if (word_taken) void'(pending_words.pop_front());
    if (running && pending_words.size() != 0 && $urandom_range(99) >= src_idle) begin
      push <= 1'b1;
      in_sample_x <= pending_words[0].sx;
      in_sample_y <= pending_words[0].sy;
      in_button_pressed <= pending_words[0].btn;
    end else begin
      push <= 1'b0;
    end
    pop <= running && ($urandom_range(99) >= snk_idle);
  end

  // monitor
  always @(posedge clk) begin
    servo_result_t want;
    word_taken = push && !full;
    if (word_taken) begin
      predict_stick('{sx: in_sample_x, sy: in_sample_y, btn: in_button_pressed});
      words_sent++;
    end
    if (pop && !empty) begin
      results_seen++;
      if (out_kind == KIND_ANGLE) angles_seen++;
      else notices_seen++;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected word kind=%0d angle=%0d last=%0d",
                 $time, out_kind, out_angle, out_last);
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (out_kind !== want.kind)
          begin $display("%0t: kind expected %0d actual %0d", $time, want.kind, out_kind);
          errors++; end
        if (out_angle !== want.angle)
          begin $display("%0t: angle expected %0d actual %0d", $time, want.angle, out_angle);
          errors++; end
        if (out_last !== want.last)
          begin $display("%0t: last expected %0d actual %0d", $time, want.last, out_last);
          errors++; end
      end
    end
  end

  // watchdog on cycles with no handshake
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WD_LIMIT) begin
      $display("%0t: watchdog expired", $time);
      $display("tb_top: done, errors");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < DEPTH; i++) begin x_hist[i] = 0; y_hist[i] = 0; end
    x_acc = 0; y_acc = 0; hist_slot = 0; in_auto = 1;
    cfg_cx = CENTER_RST; cfg_cy = CENTER_RST; cfg_wake = WAKE_RST; cfg_dead = DEAD_RST;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // phase 1: reset settings, directed words then gestures
    src_idle = 7; snk_idle = 66;
    repeat (6) pending_words.push_back('{sx: 12'd2048, sy: 12'd4095, btn: 1'b0});
    pending_words.push_back('{sx: 12'd2048, sy: 12'd4095, btn: 1'b1});
    repeat (5) pending_words.push_back('{sx: 12'd0, sy: 12'd0, btn: 1'b0});
    pending_words.push_back('{sx: 12'd0, sy: 12'd0, btn: 1'b1});
    repeat (4) pending_words.push_back('{sx: 12'd4095, sy: 12'd0, btn: 1'b0});
    repeat (4) pending_words.push_back('{sx: 12'd4095, sy: 12'd4095, btn: 1'b0});
    repeat (3) pending_words.push_back('{sx: 12'd0, sy: 12'd4095, btn: 1'b1});
    running = 1;
    add_gestures(470);
    drain_all();

    // phase 2: extreme centers, zero thresholds
    set_centers_thresholds(0, 4095, 0, 0);
    add_gestures(490);
    drain_all();

    // phase 3: opposite centers, thresholds at 5792
    src_idle = 66; snk_idle = 7;
    set_centers_thresholds(4095, 0, 5792, 5792);
    add_gestures(490);
    drain_all();

    // phase 4: random settings, no idling
    src_idle = 0; snk_idle = 0;
    set_centers_thresholds($urandom_range(4095), $urandom_range(4095),
                           $urandom_range(800), $urandom_range(300));
    add_gestures(490);
    drain_all();

    if (expected_results.size() != 0) begin
      $display("%0t: %0d expected words never arrived", $time, expected_results.size());
      errors++;
    end
    $display("covered %0d stick words over four register settings", words_sent);
    $display("checked %0d results: %0d angles, %0d auto notices, %0d mismatches",
             results_seen, angles_seen, notices_seen, errors);
    if (errors == 0) $display("tb_top: done, clean");
    else $display("tb_top: done, errors");
    $finish;
  end

endmodule
`default_nettype wire
